// ----- hdl/rlb_pkg.sv -----
// ----------------------------------------------------------------------------
// rlb_pkg
// Shared types, constants and fixed-point helpers for the RGBA layer blender.
// ----------------------------------------------------------------------------
package rlb_pkg;

  typedef logic [16:0] q16_t;
  typedef logic [255:0][16:0] dtab_t;

  localparam q16_t ONE  = 17'h10000;
  localparam q16_t HALF = 17'h08000;

  typedef enum logic [3:0] {
    MODE_NORMAL   = 4'd0,
    MODE_DARKEN   = 4'd1,
    MODE_MULTIPLY = 4'd2,
    MODE_BURN     = 4'd3,
    MODE_LIGHTEN  = 4'd4,
    MODE_SCREEN   = 4'd5,
    MODE_PLUS     = 4'd6,
    MODE_DODGE    = 4'd7,
    MODE_OVERLAY  = 4'd8,
    MODE_SOFT     = 4'd9,
    MODE_HARD     = 4'd10,
    MODE_DIFF     = 4'd11,
    MODE_EXCL     = 4'd12
  } mode_t;

  localparam logic REG_BLEND_MODE    = 1'b0;
  localparam logic REG_LAYER_OPACITY = 1'b1;

  // Divider steps, one quotient bit per stage.
  localparam int DIV_STEPS = 16;
  // Non-division blends are ready at stage 3 and wait for the quotient.
  localparam int ND_DEPTH  = DIV_STEPS - 2;
  localparam int LANE_LAT  = DIV_STEPS + 1;
  localparam int MIX_LAT   = 3;
  localparam int OUT_LAT   = LANE_LAT + MIX_LAT;

  // Skip thresholds: opacity*1000 <= 2^16 and (opacity*mask)*1000 <= 2^32.
  localparam logic [16:0] SKIP_OP_MAX = 17'd65;
  localparam logic [33:0] SKIP_OM_MAX = 34'd4294967;

  // c*65536/255 rounded equals c*257 plus one for the upper half of codes.
  function automatic q16_t to_q16(input logic [7:0] c);
    return {1'b0, c, c} + {16'b0, c[7]};
  endfunction

  function automatic q16_t sat1(input logic [17:0] v);
    return (v > 18'(ONE)) ? ONE : v[16:0];
  endfunction

  function automatic longint unsigned sqrt_round(input longint unsigned x);
    longint unsigned r;
    longint unsigned bt;
    longint unsigned v;
    r  = 0;
    bt = 64'h4000_0000_0000_0000;
    v  = x;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= r + bt) begin
        v = v - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    if (x - r * r > r) r = r + 1;
    return r;
  endfunction

  // Soft-light D(b) for every base code: a cubic for dark bases, else sqrt.
  function automatic dtab_t build_dtab();
    dtab_t tab;
    longint unsigned b;
    longint unsigned b2;
    longint unsigned b3;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned d;
    tab = '0;
    for (int c = 0; c < 256; c++) begin
      b = 64'(to_q16(8'(c)));
      if (b <= 64'd16384) begin
        b2  = (b * b + 64'd32768) >> 16;
        b3  = (b2 * b + 64'd32768) >> 16;
        pos = 4 * b + 16 * b3;
        neg = 12 * b2;
        d   = (pos > neg) ? pos - neg : 64'd0;
      end else begin
        d = sqrt_round(b << 16);
      end
      tab[c] = 17'(d);
    end
    return tab;
  endfunction

  localparam dtab_t D_TAB = build_dtab();

endpackage

// ----- hdl/rlb_div.sv -----
// ----------------------------------------------------------------------------
// rlb_div
// Pipelined restoring divider: one quotient bit per stage, 16-bit quotient.
// ----------------------------------------------------------------------------
module rlb_div import rlb_pkg::*; (
  input  logic                 clk,
  input  logic [32:0]          num,
  input  q16_t                 den,
  output logic [DIV_STEPS-1:0] quot
);

  q16_t                 rem   [DIV_STEPS];
  logic [15:0]          low   [DIV_STEPS];
  q16_t                 dens  [DIV_STEPS];
  logic [DIV_STEPS-1:0] qacc  [DIV_STEPS];

  q16_t                 rem_next  [DIV_STEPS];
  logic [15:0]          low_next  [DIV_STEPS];
  q16_t                 den_next  [DIV_STEPS];
  logic [DIV_STEPS-1:0] qacc_next [DIV_STEPS];

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      q16_t                 src_rem;
      logic [15:0]          src_low;
      q16_t                 src_den;
      logic [DIV_STEPS-1:0] src_q;
      logic [17:0]          t;
      if (k == 0) begin
        src_rem = num[32:16];
        src_low = num[15:0];
        src_den = den;
        src_q   = '0;
      end else begin
        src_rem = rem[k-1];
        src_low = low[k-1];
        src_den = dens[k-1];
        src_q   = qacc[k-1];
      end
      t = {src_rem, src_low[15]};
      if (t >= 18'(src_den)) begin
        rem_next[k]  = 17'(t - 18'(src_den));
        qacc_next[k] = {src_q[DIV_STEPS-2:0], 1'b1};
      end else begin
        rem_next[k]  = t[16:0];
        qacc_next[k] = {src_q[DIV_STEPS-2:0], 1'b0};
      end
      low_next[k] = {src_low[14:0], 1'b0};
      den_next[k] = src_den;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      rem[k]  <= rem_next[k];
      low[k]  <= low_next[k];
      dens[k] <= den_next[k];
      qacc[k] <= qacc_next[k];
    end
  end

  assign quot = qacc[DIV_STEPS-1];

endmodule

// ----- hdl/rlb_lane.sv -----
// ----------------------------------------------------------------------------
// rlb_lane
// One color channel: converts both codes to Q16 and forms the blend value.
// ----------------------------------------------------------------------------
module rlb_lane import rlb_pkg::*; (
  input  logic       clk,
  input  logic [7:0] base_code,
  input  logic [7:0] layer_code,
  input  mode_t      mode,
  output q16_t       base_q,
  output q16_t       blend_q
);

  typedef struct packed {
    q16_t  nd;
    q16_t  bq;
    mode_t mode;
    logic  ovf;
  } nd_t;

  q16_t        bq, sq, den, dq;
  logic [32:0] num;
  logic        ovf;
  logic [DIV_STEPS-1:0] quot;

  always_comb begin
    bq = to_q16(base_code);
    sq = to_q16(layer_code);
    dq = D_TAB[base_code];
    if (mode == MODE_DODGE) begin
      den = ONE - sq;
      num = {bq, 16'b0} + 33'(den >> 1);
    end else begin
      den = sq;
      num = {q16_t'(ONE - bq), 16'b0} + 33'(sq >> 1);
    end
    // A quotient of one or more saturates; this also covers a zero divisor.
    ovf = num[32:16] >= den;
  end

  rlb_div u_div (
    .clk  (clk),
    .num  (num),
    .den  (den),
    .quot (quot)
  );

  // Stage 1: products.
  q16_t        r1_bq, r1_sq, r1_k, r1_diff;
  mode_t       r1_mode;
  logic        r1_ovf, r1_dge;
  logic [33:0] r1_bs, r1_ibs, r1_m1;

  always_ff @(posedge clk) begin
    r1_bq   <= bq;
    r1_sq   <= sq;
    r1_mode <= mode;
    r1_ovf  <= ovf;
    r1_bs   <= 34'(bq) * 34'(sq);
    r1_ibs  <= 34'(q16_t'(ONE - bq)) * 34'(q16_t'(ONE - sq));
    r1_m1   <= 34'(q16_t'(ONE - {sq[15:0], 1'b0})) * 34'(bq);
    r1_k    <= q16_t'({sq[15:0], 1'b0} - ONE);
    r1_dge  <= dq >= bq;
    r1_diff <= (dq >= bq) ? dq - bq : bq - dq;
  end

  // Stage 2: rounding of products and the second soft-light multiply.
  q16_t        qbs, t1, lo_l, hi_l;
  logic [17:0] t2, it2, sum_bs;

  always_comb begin
    qbs    = 17'((r1_bs + 34'(HALF)) >> 16);
    t2     = 18'(((35'(r1_bs) << 1) + 35'(HALF)) >> 16);
    it2    = 18'(((35'(r1_ibs) << 1) + 35'(HALF)) >> 16);
    t1     = 17'((r1_m1 + 34'(HALF)) >> 16);
    sum_bs = 18'(r1_bq) + 18'(r1_sq);
    lo_l   = sat1(t2);
    hi_l   = (it2 >= 18'(ONE)) ? '0 : q16_t'(ONE - it2[16:0]);
  end

  q16_t        r2_bq, r2_sq, r2_mult, r2_screen, r2_plus, r2_excl, r2_ovl, r2_hard;
  mode_t       r2_mode;
  logic        r2_ovf, r2_dge;
  logic [33:0] r2_slp, r2_kd;

  always_ff @(posedge clk) begin
    r2_bq     <= r1_bq;
    r2_sq     <= r1_sq;
    r2_mode   <= r1_mode;
    r2_ovf    <= r1_ovf;
    r2_dge    <= r1_dge;
    r2_mult   <= qbs;
    r2_screen <= sat1(sum_bs - 18'(qbs));
    r2_plus   <= sat1(sum_bs);
    r2_excl   <= (sum_bs > t2) ? sat1(sum_bs - t2) : '0;
    r2_ovl    <= (r1_bq < HALF) ? lo_l : hi_l;
    r2_hard   <= (r1_sq < HALF) ? lo_l : hi_l;
    r2_slp    <= 34'(t1) * 34'(q16_t'(ONE - r1_bq));
    r2_kd     <= 34'(r1_k) * 34'(r1_diff);
  end

  // Stage 3: select the non-division blend.
  q16_t ts, tk, soft_v, nd;

  always_comb begin
    ts = 17'((r2_slp + 34'(HALF)) >> 16);
    tk = 17'((r2_kd + 34'(HALF)) >> 16);
    if (r2_sq <= HALF) begin
      soft_v = (ts > r2_bq) ? '0 : r2_bq - ts;
    end else if (r2_dge) begin
      soft_v = sat1(18'(r2_bq) + 18'(tk));
    end else begin
      soft_v = (tk > r2_bq) ? '0 : r2_bq - tk;
    end
    case (r2_mode)
      MODE_DARKEN:   nd = (r2_bq < r2_sq) ? r2_bq : r2_sq;
      MODE_MULTIPLY: nd = r2_mult;
      MODE_LIGHTEN:  nd = (r2_bq > r2_sq) ? r2_bq : r2_sq;
      MODE_SCREEN:   nd = r2_screen;
      MODE_PLUS:     nd = r2_plus;
      MODE_OVERLAY:  nd = r2_ovl;
      MODE_SOFT:     nd = soft_v;
      MODE_HARD:     nd = r2_hard;
      MODE_DIFF:     nd = (r2_bq > r2_sq) ? r2_bq - r2_sq : r2_sq - r2_bq;
      MODE_EXCL:     nd = r2_excl;
      MODE_BURN:     nd = '0;
      MODE_DODGE:    nd = '0;
      default:       nd = r2_sq;
    endcase
  end

  nd_t dl [ND_DEPTH];

  always_ff @(posedge clk) begin
    dl[0] <= '{nd: nd, bq: r2_bq, mode: r2_mode, ovf: r2_ovf};
    for (int i = 1; i < ND_DEPTH; i++) begin
      dl[i] <= dl[i-1];
    end
  end

  // Final stage: quotient and delayed blend meet here.
  nd_t last;
  assign last = dl[ND_DEPTH-1];

  always_ff @(posedge clk) begin
    base_q <= last.bq;
    case (last.mode)
      MODE_BURN:  blend_q <= last.ovf ? '0 : q16_t'(ONE - {1'b0, quot});
      MODE_DODGE: blend_q <= last.ovf ? ONE : {1'b0, quot};
      default:    blend_q <= last.nd;
    endcase
  end

endmodule

// ----- hdl/rlb_mix.sv -----
// ----------------------------------------------------------------------------
// rlb_mix
// Weighted mix of base and blend values, rounded and clamped to 8 bits.
// ----------------------------------------------------------------------------
module rlb_mix import rlb_pkg::*; (
  input  logic       clk,
  input  q16_t       base_q,
  input  q16_t       blend_q,
  input  q16_t       eff,
  output logic [7:0] byte_out
);

  logic [33:0] p_b, p_l;
  logic [34:0] acc;
  logic [42:0] scaled;
  logic [10:0] v;

  always_ff @(posedge clk) begin
    p_b <= 34'(base_q) * 34'(q16_t'(ONE - eff));
    p_l <= 34'(blend_q) * 34'(eff);
    acc <= 35'(p_b) + 35'(p_l);
  end

  // acc*255 done as acc*256 - acc.
  always_comb begin
    scaled = (43'(acc) << 8) - 43'(acc) + (43'd1 << 31);
    v      = scaled[42:32];
  end

  always_ff @(posedge clk) begin
    byte_out <= (v > 11'd255) ? 8'hFF : v[7:0];
  end

endmodule

// ----- hdl/rgba_layer_blend_pixel.sv -----
// ----------------------------------------------------------------------------
// rgba_layer_blend_pixel
// Blends one RGBA8 layer pixel over a destination pixel per item.
// ----------------------------------------------------------------------------
// Usage: drive dest_pixel, src_pixel and pixel_mask with start high; the
// item is taken at that clock edge. busy is always low, so a new item may
// be started in every cycle and the block sustains one item per cycle.
// The result appears on out_pixel and pixel_written, marked by done for
// exactly one cycle. The latency is set by the per-channel divider
// used by burn and dodge, which resolves one quotient bit per stage,
// followed by the three-stage output mix.
// The receiver cannot hold results off; every item yields exactly one
// result, in order. R, G and B run in three parallel lanes and a merging
// stage packs them with the alpha mix or returns the destination when
// the pixel is skipped. The user must set blend_mode (address 0) and
// layer_opacity (address 4) over the APB port only while no item is in
// flight; the block does not enforce this. Reset clears the pipeline
// valid bits and sets blend_mode to normal and layer_opacity to one.
// ----------------------------------------------------------------------------
module rgba_layer_blend_pixel import rlb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] dest_pixel,
  input  logic [31:0] src_pixel,
  input  logic [16:0] pixel_mask,
  output logic        done,
  output logic [31:0] out_pixel,
  output logic        pixel_written,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0]  blend_mode;
  logic [16:0] layer_opacity;

  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode    <= 4'(MODE_NORMAL);
      layer_opacity <= ONE;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_BLEND_MODE:    blend_mode    <= pwdata[3:0];
        REG_LAYER_OPACITY: layer_opacity <= pwdata[16:0];
        default:           blend_mode    <= blend_mode;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BLEND_MODE:    prdata = {28'b0, blend_mode};
      REG_LAYER_OPACITY: prdata = {15'b0, layer_opacity};
      default:           prdata = '0;
    endcase
  end

  // Stage 0: item registers.
  logic [31:0] t0_src;
  logic [16:0] t0_mask, t0_op;
  mode_t       t0_mode;
  logic [OUT_LAT:0] vld;
  logic [31:0] dest_dl [OUT_LAT+1];

  always_ff @(posedge clk) begin
    t0_src     <= src_pixel;
    t0_mask    <= pixel_mask;
    t0_op      <= layer_opacity;
    t0_mode    <= mode_t'(blend_mode);
    dest_dl[0] <= dest_pixel;
    for (int i = 1; i <= OUT_LAT; i++) begin
      dest_dl[i] <= dest_dl[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[OUT_LAT-1:0], start};
    end
  end

  // Effective weight: opacity * mask * layer alpha, clamped to one.
  logic [33:0] e1_om;
  logic        e1_skip;
  logic [7:0]  e1_sa;
  logic [18:0] omr;
  logic [35:0] e2_p;
  logic [19:0] effw;
  q16_t        eff_dl  [LANE_LAT-2];
  logic        skip_dl [OUT_LAT-1];

  always_ff @(posedge clk) begin
    e1_om   <= 34'(t0_op) * 34'(t0_mask);
    e1_skip <= (t0_src[31:24] == 8'd0) || (t0_op <= SKIP_OP_MAX);
    e1_sa   <= t0_src[31:24];
  end

  always_comb begin
    omr  = 19'((e1_om + 34'(HALF)) >> 16);
    effw = 20'((e2_p + 36'(HALF)) >> 16);
  end

  always_ff @(posedge clk) begin
    e2_p       <= 36'(omr) * 36'(to_q16(e1_sa));
    skip_dl[0] <= e1_skip || (e1_om <= SKIP_OM_MAX);
    for (int i = 1; i < OUT_LAT - 1; i++) begin
      skip_dl[i] <= skip_dl[i-1];
    end
    eff_dl[0] <= (effw > 20'(ONE)) ? ONE : effw[16:0];
    for (int i = 1; i < LANE_LAT - 2; i++) begin
      eff_dl[i] <= eff_dl[i-1];
    end
  end

  q16_t eff_l;
  assign eff_l = eff_dl[LANE_LAT-3];

  // Color lanes and their mixers.
  q16_t       base_q  [3];
  q16_t       blend_q [3];
  logic [7:0] ch_byte [4];

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    rlb_lane u_lane (
      .clk        (clk),
      .base_code  (dest_dl[0][8*ch +: 8]),
      .layer_code (t0_src[8*ch +: 8]),
      .mode       (t0_mode),
      .base_q     (base_q[ch]),
      .blend_q    (blend_q[ch])
    );

    rlb_mix u_mix (
      .clk      (clk),
      .base_q   (base_q[ch]),
      .blend_q  (blend_q[ch]),
      .eff      (eff_l),
      .byte_out (ch_byte[ch])
    );
  end

  // Alpha is a mix of the destination alpha toward one.
  rlb_mix u_mix_alpha (
    .clk      (clk),
    .base_q   (to_q16(dest_dl[LANE_LAT][31:24])),
    .blend_q  (ONE),
    .eff      (eff_l),
    .byte_out (ch_byte[3])
  );

  // Merge: pack the lanes or pass the destination through.
  logic out_skip;
  assign out_skip = skip_dl[OUT_LAT-2];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[OUT_LAT];
    end
  end

  always_ff @(posedge clk) begin
    pixel_written <= !out_skip;
    out_pixel     <= out_skip ? dest_dl[OUT_LAT]
                              : {ch_byte[3], ch_byte[2], ch_byte[1], ch_byte[0]};
  end

  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, OUT_LAT + 2))
    else $error("result strobe without a matching item");

  a_skip_passes_dest: assert property (@(posedge clk) disable iff (rst)
    (done && !pixel_written) |-> (out_pixel == $past(dest_pixel, OUT_LAT + 2)))
    else $error("skipped item did not return the destination pixel");

  a_written_has_alpha: assert property (@(posedge clk) disable iff (rst)
    (done && pixel_written) |-> ($past(src_pixel[31:24], OUT_LAT + 2) != 8'd0))
    else $error("item with zero layer alpha was blended");

endmodule
